### hw/rtl/dast_pkg.sv
// ----------------------------------------------------------------------------
// dast_pkg
// Shared types and constants of the daily alarm schedule table: commands,
// status codes, the layout of one alarm slot and the compare unit's flags.
// ----------------------------------------------------------------------------
package dast_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MINUTE_W    = 6;
  localparam int unsigned DAY_W       = 9;
  localparam int unsigned SLOT_IN_W   = 4;
  localparam int unsigned SLOT_OUT_W  = 3;
  localparam int unsigned FIRE_CNT_W  = 4;

  localparam logic [HOUR_W-1:0]     MAX_HOUR   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0]   MAX_MINUTE = MINUTE_W'(59);
  localparam logic [FIRE_CNT_W-1:0] MAX_FIRE   = FIRE_CNT_W'(8);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_TIME = 2'd1,
    STS_FULL     = 2'd2,
    STS_BAD_IDX  = 2'd3
  } status_e;

  typedef struct packed {
    logic                active;
    logic                enabled;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                turn_on;
    logic                fired;
  } alarm_t;

  // Flags from the shared compare unit for the slot under the scan pointer.
  typedef struct packed {
    logic free;
    logic hit;
  } cmp_t;

endpackage

### hw/rtl/daily_alarm_schedule_table_unit.sv
// ----------------------------------------------------------------------------
// daily_alarm_schedule_table_unit
// Table of daily alarms with add, delete, toggle and time tick commands.
// ----------------------------------------------------------------------------
// Delete and toggle go from accept through an execute state to a done state
// that registers the result; add and a synced tick walk the slots through one
// compare unit, one slot a cycle, between those two states. A tick that fires
// several alarms also waits for each earlier result to be taken. The next
// transaction is accepted in the cycle after the last result is registered.
// Reset clears all slots, the stored day and the output register.
module daily_alarm_schedule_table_unit
  import dast_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // hour[4:0], minute[10:5], switch_on[11], slot_index[15:12],
  // day_of_year[24:16], clock_synced[25], zero fill [31:26]
  input  logic [31:0] s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], slot[4:2], fired[5], action_on[6], zero fill [7]
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  alarm_t                 entries_q [ENTRIES];
  logic [DAY_W-1:0]       prev_day_q;
  logic                   prev_day_valid_q;

  cmd_e                   cmd_q;
  logic [HOUR_W-1:0]      hour_q;
  logic [MINUTE_W-1:0]    minute_q;
  logic                   switch_on_q;
  logic [SLOT_IN_W-1:0]   idx_q;
  logic [DAY_W-1:0]       day_q;
  logic                   synced_q;

  logic [IDX_W-1:0]       cnt_q;
  logic [FIRE_CNT_W-1:0]  fire_cnt_q;
  status_e                res_status_q;
  logic [SLOT_OUT_W-1:0]  res_slot_q;
  logic                   res_fired_q;
  logic                   res_action_q;

  logic                   m_valid_q;
  status_e                m_status_q;
  logic [SLOT_OUT_W-1:0]  m_slot_q;
  logic                   m_fired_q;
  logic                   m_action_q;
  logic                   m_last_q;

  alarm_t                 cur_entry;
  cmp_t                   cmp;
  logic                   out_free;
  logic                   cnt_last;
  logic                   hit_ok;
  logic                   idx_bad;
  logic [IDX_W-1:0]       idx_sel;
  logic                   m_load;

  assign cur_entry = entries_q[cnt_q];
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign cnt_last  = (cnt_q == IDX_W'(ENTRIES - 1));
  assign hit_ok    = cmp.hit && (fire_cnt_q != MAX_FIRE);
  assign idx_sel   = idx_q[IDX_W-1:0];
  assign idx_bad   = ({1'b0, idx_q} >= (SLOT_IN_W + 1)'(ENTRIES)) ||
                     !entries_q[idx_sel].active;
  // The output register loads the final result, or a held firing that a later
  // firing has shown not to be the final one.
  assign m_load    = out_free && ((state_q == ST_DONE) ||
                     (state_q == ST_SCAN && cmd_q != CMD_ADD && hit_ok && res_fired_q));

  dast_cmp u_cmp (
    .entry_i  (cur_entry),
    .hour_i   (hour_q),
    .minute_i (minute_q),
    .cmp_o    (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      entries_q        <= '{default: '0};
      prev_day_q       <= '0;
      prev_day_valid_q <= 1'b0;
      cmd_q            <= CMD_ADD;
      hour_q           <= '0;
      minute_q         <= '0;
      switch_on_q      <= 1'b0;
      idx_q            <= '0;
      day_q            <= '0;
      synced_q         <= 1'b0;
      cnt_q            <= '0;
      fire_cnt_q       <= '0;
      res_status_q     <= STS_OK;
      res_slot_q       <= '0;
      res_fired_q      <= 1'b0;
      res_action_q     <= 1'b0;
      m_valid_q        <= 1'b0;
      m_status_q       <= STS_OK;
      m_slot_q         <= '0;
      m_fired_q        <= 1'b0;
      m_action_q       <= 1'b0;
      m_last_q         <= 1'b0;
    end else begin
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q       <= cmd_e'(s_axis_tuser_i);
            hour_q      <= s_axis_tdata_i[4:0];
            minute_q    <= s_axis_tdata_i[10:5];
            switch_on_q <= s_axis_tdata_i[11];
            idx_q       <= s_axis_tdata_i[15:12];
            day_q       <= s_axis_tdata_i[24:16];
            synced_q    <= s_axis_tdata_i[25];
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_status_q <= STS_OK;
          res_slot_q   <= '0;
          res_fired_q  <= 1'b0;
          res_action_q <= 1'b0;
          cnt_q        <= '0;
          fire_cnt_q   <= '0;
          case (cmd_q)
            CMD_ADD: begin
              if (hour_q > MAX_HOUR || minute_q > MAX_MINUTE) begin
                res_status_q <= STS_BAD_TIME;
                state_q      <= ST_DONE;
              end else begin
                state_q <= ST_SCAN;
              end
            end
            CMD_DELETE, CMD_TOGGLE: begin
              if (idx_bad) begin
                res_status_q <= STS_BAD_IDX;
              end else if (cmd_q == CMD_DELETE) begin
                entries_q[idx_sel] <= '0;
              end else begin
                entries_q[idx_sel].enabled <= ~entries_q[idx_sel].enabled;
              end
              state_q <= ST_DONE;
            end
            CMD_TICK: begin
              if (!synced_q) begin
                state_q <= ST_DONE;
              end else begin
                // A new day re-arms every alarm before the scan.
                if (!prev_day_valid_q || prev_day_q != day_q) begin
                  prev_day_q       <= day_q;
                  prev_day_valid_q <= 1'b1;
                  for (int i = 0; i < ENTRIES; i++) begin
                    entries_q[i].fired <= 1'b0;
                  end
                end
                state_q <= ST_SCAN;
              end
            end
            default: state_q <= ST_DONE;
          endcase
        end
        ST_SCAN: begin
          if (cmd_q == CMD_ADD) begin
            if (cmp.free) begin
              entries_q[cnt_q] <= '{active: 1'b1, enabled: 1'b1, hour: hour_q,
                                    minute: minute_q, turn_on: switch_on_q,
                                    fired: 1'b0};
              res_slot_q <= SLOT_OUT_W'(cnt_q);
              state_q    <= ST_DONE;
            end else if (cnt_last) begin
              res_status_q <= STS_FULL;
              state_q      <= ST_DONE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else if (!(hit_ok && res_fired_q && !out_free)) begin
            // The firing held in the result register goes out only once a
            // later firing proves it is not the final one.
            if (hit_ok) begin
              if (res_fired_q) begin
                m_status_q <= res_status_q;
                m_slot_q   <= res_slot_q;
                m_fired_q  <= 1'b1;
                m_action_q <= res_action_q;
                m_last_q   <= 1'b0;
              end
              res_slot_q             <= SLOT_OUT_W'(cnt_q);
              res_fired_q            <= 1'b1;
              res_action_q           <= cur_entry.turn_on;
              entries_q[cnt_q].fired <= 1'b1;
              fire_cnt_q             <= fire_cnt_q + 1'b1;
            end
            if (cnt_last) begin
              state_q <= ST_DONE;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_status_q <= res_status_q;
            m_slot_q   <= res_slot_q;
            m_fired_q  <= res_fired_q;
            m_action_q <= res_action_q;
            m_last_q   <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_action_q, m_fired_q, m_slot_q, m_status_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

### hw/rtl/dast_cmp.sv
// ----------------------------------------------------------------------------
// dast_cmp
// Shared compare unit: checks one alarm slot for being free and for matching
// the current time as an armed, not yet fired alarm.
// ----------------------------------------------------------------------------
module dast_cmp
  import dast_pkg::*;
(
  input  alarm_t              entry_i,
  input  logic [HOUR_W-1:0]   hour_i,
  input  logic [MINUTE_W-1:0] minute_i,
  output cmp_t                cmp_o
);

  always_comb begin
    cmp_o.free = ~entry_i.active;
    cmp_o.hit  = entry_i.active && entry_i.enabled && !entry_i.fired &&
                 (entry_i.hour == hour_i) && (entry_i.minute == minute_i);
  end

endmodule

### hw/rtl/dast_chk.sv
// ----------------------------------------------------------------------------
// dast_chk
// Port-level checks of the daily alarm schedule table, bound to the top level.
// ----------------------------------------------------------------------------
module dast_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // The table works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a command is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // Only firings come in runs; every other result ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[5] |-> m_axis_tlast_o && !m_axis_tdata_o[6])
    else $error("non-firing result is not final or carries an action");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != 2'd0 |->
      !m_axis_tdata_o[5] && m_axis_tdata_o[4:2] == 3'd0)
    else $error("error result carries a slot or a firing");

endmodule

bind daily_alarm_schedule_table_unit dast_chk u_dast_chk (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the daily alarm schedule table. A queue of commands
// feeds a stream driver, and a stream monitor compares every reply with a
// cycle-free predictor of the alarm table. A directed opening covers errors,
// a full table and an eight-way firing; random phases follow with varied gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import dast_pkg::*;

  localparam int unsigned NSLOTS         = ENTRIES_DEF;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          LONG_HOLD      = 400;

  typedef struct {
    cmd_e                  cmd;
    logic [HOUR_W-1:0]     hour;
    logic [MINUTE_W-1:0]   minute;
    logic                  switch_on;
    logic [SLOT_IN_W-1:0]  slot_index;
    logic [DAY_W-1:0]      day;
    logic                  synced;
  } alarm_cmd_t;

  typedef struct {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  fired;
    logic                  action_on;
    logic                  last;
  } alarm_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = CMD_ADD;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  daily_alarm_schedule_table_unit #(
    .ENTRIES(NSLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Predicted alarm table and day tracking.
  alarm_t           alarm_table [NSLOTS];
  logic [DAY_W-1:0] known_day = '0;
  logic             day_seen = 1'b0;

  alarm_cmd_t   cmd_q [$];
  alarm_reply_t reply_q [$];
  alarm_cmd_t   drv_cmd;
  logic         drv_valid = 1'b0;
  logic         took_cmd = 1'b0;
  int           gap_cnt = 0;
  int           stall_cnt = 0;
  int           hold_cnt = 0;
  logic         hold_req = 1'b0;
  logic         tx_gaps = 1'b1;
  logic         rx_stalls = 1'b1;
  int           err_cnt = 0;
  int           idle_cycles = 0;

  logic [HOUR_W-1:0]   pool_hour [4];
  logic [MINUTE_W-1:0] pool_minute [4];
  logic [DAY_W-1:0]    cur_day = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic predict_reply(input alarm_cmd_t c);
    alarm_reply_t r;
    int           n;
    bit           placed;
    r = '{STS_OK, '0, 1'b0, 1'b0, 1'b1};
    n = 0;
    placed = 0;
    case (c.cmd)
      CMD_ADD: begin
        if (c.hour > MAX_HOUR || c.minute > MAX_MINUTE) begin
          r.status = STS_BAD_TIME;
        end else begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (!placed && !alarm_table[i].active) begin
              alarm_table[i] = '{1'b1, 1'b1, c.hour, c.minute, c.switch_on, 1'b0};
              r.slot = SLOT_OUT_W'(i);
              placed = 1;
            end
          end
          if (!placed) r.status = STS_FULL;
        end
        reply_q.push_back(r);
      end
      CMD_DELETE, CMD_TOGGLE: begin
        if (c.slot_index >= NSLOTS || !alarm_table[c.slot_index].active) begin
          r.status = STS_BAD_IDX;
        end else if (c.cmd == CMD_DELETE) begin
          alarm_table[c.slot_index] = '0;
        end else begin
          alarm_table[c.slot_index].enabled = ~alarm_table[c.slot_index].enabled;
        end
        reply_q.push_back(r);
      end
      default: begin
        if (c.synced) begin
          // A new day, or the first synced tick, re-arms every alarm.
          if (!day_seen || known_day != c.day) begin
            known_day = c.day;
            day_seen = 1'b1;
            for (int i = 0; i < NSLOTS; i++) alarm_table[i].fired = 1'b0;
          end
          for (int i = 0; i < NSLOTS && n < MAX_FIRE; i++) begin
            if (alarm_table[i].active && alarm_table[i].enabled && !alarm_table[i].fired &&
                alarm_table[i].hour == c.hour && alarm_table[i].minute == c.minute) begin
              alarm_table[i].fired = 1'b1;
              reply_q.push_back('{STS_OK, SLOT_OUT_W'(i), 1'b1, alarm_table[i].turn_on,
                                  1'b0});
              n++;
            end
          end
          if (n > 0) reply_q[reply_q.size()-1].last = 1'b1;
        end
        if (n == 0) reply_q.push_back(r);
      end
    endcase
  endtask

  // Driver: offers the next pending command after an optional gap.
  always @(negedge clk_i) begin
    if (took_cmd) begin
      drv_valid = 1'b0;
      took_cmd = 1'b0;
      gap_cnt = tx_gaps ? gap_len() : 0;
    end
    if (rst_ni && !drv_valid) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
      end else if (cmd_q.size() > 0) begin
        drv_cmd = cmd_q.pop_front();
        drv_valid = 1'b1;
      end
    end
    s_axis_tvalid_i <= drv_valid;
    s_axis_tdata_i  <= {6'b0, drv_cmd.synced, drv_cmd.day, drv_cmd.slot_index,
                        drv_cmd.switch_on, drv_cmd.minute, drv_cmd.hour};
    s_axis_tuser_i  <= drv_cmd.cmd;
  end

  // Receiver ready: random stalls plus an occasional long hold-off.
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_req) begin
      hold_cnt = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (rx_stalls && $urandom_range(0, 3) == 0) stall_cnt = gap_len();
    end
    m_axis_tready_i <= rdy;
  end

  // Input transactions update the prediction; output transactions are checked.
  always @(posedge clk_i) begin
    alarm_reply_t exp_r;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_reply(drv_cmd);
      took_cmd = 1'b1;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (reply_q.size() == 0) begin
        $error("reply with nothing expected: data %h last %b", m_axis_tdata_o,
               m_axis_tlast_o);
        err_cnt++;
      end else begin
        exp_r = reply_q.pop_front();
        if (m_axis_tdata_o[1:0] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tdata_o[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[4:2] !== exp_r.slot) begin
          $error("slot: expected %0d, actual %0d", exp_r.slot, m_axis_tdata_o[4:2]);
          err_cnt++;
        end
        if (m_axis_tdata_o[5] !== exp_r.fired) begin
          $error("fired: expected %0d, actual %0d", exp_r.fired, m_axis_tdata_o[5]);
          err_cnt++;
        end
        if (m_axis_tdata_o[6] !== exp_r.action_on) begin
          $error("action_on: expected %0d, actual %0d", exp_r.action_on, m_axis_tdata_o[6]);
          err_cnt++;
        end
        if (m_axis_tlast_o !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, m_axis_tlast_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_cmd(input cmd_e cmd, input int hour, input int minute,
                           input int on, input int idx, input int day, input int synced);
    alarm_cmd_t c;
    c.cmd        = cmd;
    c.hour       = HOUR_W'(hour);
    c.minute     = MINUTE_W'(minute);
    c.switch_on  = 1'(on);
    c.slot_index = SLOT_IN_W'(idx);
    c.day        = DAY_W'(day);
    c.synced     = 1'(synced);
    cmd_q.push_back(c);
  endtask

  // Times come mostly from a small pool so that ticks hit stored alarms.
  task automatic queue_random_cmds(input int count);
    alarm_cmd_t c;
    int         pick;
    int         p;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      c.cmd = CMD_ADD;
      else if (pick < 45) c.cmd = CMD_DELETE;
      else if (pick < 57) c.cmd = CMD_TOGGLE;
      else                c.cmd = CMD_TICK;
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, 3);
        c.hour   = pool_hour[p];
        c.minute = pool_minute[p];
      end else begin
        c.hour   = HOUR_W'($urandom_range(0, 31));
        c.minute = MINUTE_W'($urandom_range(0, 63));
      end
      c.switch_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) c.slot_index = SLOT_IN_W'($urandom_range(0, NSLOTS - 1));
      else                            c.slot_index = SLOT_IN_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) cur_day = DAY_W'($urandom_range(0, 511));
      c.day    = cur_day;
      c.synced = ($urandom_range(0, 9) != 0);
      cmd_q.push_back(c);
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || drv_valid || reply_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) alarm_table[i] = '0;
    for (int i = 0; i < 4; i++) begin
      pool_hour[i]   = HOUR_W'($urandom_range(0, 23));
      pool_minute[i] = MINUTE_W'($urandom_range(0, 59));
    end
    pool_hour[0]   = HOUR_W'(23);
    pool_minute[0] = MINUTE_W'(59);
    cur_day = DAY_W'($urandom_range(0, 365));
    drv_cmd = '{CMD_ADD, '0, '0, 1'b0, '0, '0, 1'b0};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Errors on an empty table and an unsynced tick with every field at its top.
    queue_cmd(CMD_DELETE, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_TOGGLE, 0, 0, 0, 15, 0, 0);
    queue_cmd(CMD_TICK, 31, 63, 1, 15, 511, 0);
    queue_cmd(CMD_ADD, 24, 0, 1, 0, 0, 0);
    queue_cmd(CMD_ADD, 0, 60, 1, 0, 0, 0);
    queue_cmd(CMD_ADD, 31, 63, 1, 0, 0, 0);
    // Fill every slot with the same time, then overflow the table.
    for (int i = 0; i < NSLOTS; i++) queue_cmd(CMD_ADD, 23, 59, i % 2, 0, 0, 0);
    queue_cmd(CMD_ADD, 0, 0, 1, 0, 0, 0);
    // First synced tick fires all slots; a repeat on the same day fires none.
    queue_cmd(CMD_TICK, 23, 59, 0, 0, 365, 1);
    queue_cmd(CMD_TICK, 23, 59, 0, 0, 365, 1);
    queue_cmd(CMD_TOGGLE, 0, 0, 0, 3, 0, 0);
    queue_cmd(CMD_DELETE, 0, 0, 0, 7, 0, 0);
    queue_cmd(CMD_DELETE, 0, 0, 0, NSLOTS, 0, 0);
    queue_cmd(CMD_TOGGLE, 0, 0, 0, 7, 0, 0);
    // An out-of-range day is just another day and re-arms the table.
    queue_cmd(CMD_TICK, 23, 59, 0, 0, 511, 1);
    queue_cmd(CMD_ADD, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_TICK, 0, 0, 0, 0, 0, 1);
    queue_cmd(CMD_TICK, 31, 63, 0, 0, 0, 1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      tx_gaps   = (p == 0 || p == 2);
      rx_stalls = (p == 0 || p == 3);
      if (p == 0) hold_req = 1'b1;
      queue_random_cmds(36);
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
